>>> rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window median package
// Sizes, the window entry layout and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int WINDOW_DEPTH = 256;
    localparam int SAMPLE_BITS  = 32;
    localparam int ADDR_BITS    = $clog2(WINDOW_DEPTH);
    localparam int COUNT_BITS   = $clog2(WINDOW_DEPTH + 1);
    localparam int LIMIT_BITS   = 9;
    localparam int OUT_BITS     = SAMPLE_BITS + 1;
    localparam int CMP_BITS     = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(240);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic [ADDR_BITS-1:0]   age;
    } t_entry;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_MID,
        RD_MID_M1
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_DEL,
        WR_SHIFT,
        WR_NEW_UP,
        WR_NEW_ZERO
    } t_wr_sel;

    typedef struct packed {
        logic    take_in;
        logic    idx_zero;
        logic    idx_top;
        logic    idx_inc;
        logic    idx_dec;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    med_zero;
        logic    med_odd;
        logic    med_hi;
        logic    med_sum;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic samp_valid;
        logic n_zero;
        logic n_full;
        logic n_over_lim;
        logic n_odd;
        logic idx_last;
        logic idx_zero;
        logic age_match;
        logic greater;
    } t_sts;

endpackage

>>> rtl/swm_ctrl.sv
// ----------------------------------------------------------------------------
// Sliding window median controller
// Sequences sorted insertion, removal of the oldest entry, trimming to the
// limit and the median read for each accepted word.
// ----------------------------------------------------------------------------
module swm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  swm_pkg::t_sts i_sts,
    output swm_pkg::t_cmd o_cmd
);
    import swm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_NEXT,
        S_DEL_START,
        S_DEL_RD,
        S_DEL_ACT,
        S_INS_START,
        S_INS_RD,
        S_INS_ACT,
        S_INS_LAST,
        S_MED_RD0,
        S_MED_RD1,
        S_MED_LO,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_found;
    logic   n_found;
    logic   r_pend;
    logic   n_pend;
    logic   r_out_valid;
    logic   n_out_valid;
    t_cmd   w_cmd;

    always_comb begin
        n_state     = r_state;
        n_found     = r_found;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !i_ready;
        w_cmd       = '0;
        w_cmd.rd_sel = RD_IDX;
        w_cmd.wr_sel = WR_DEL;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    w_cmd.take_in = 1'b1;
                    n_state       = S_START;
                end
            end
            S_START: begin
                n_pend  = i_sts.samp_valid;
                n_state = S_NEXT;
            end
            S_NEXT: begin
                if (r_pend && i_sts.n_full) begin
                    n_state = S_DEL_START;
                end else if (r_pend) begin
                    n_state = S_INS_START;
                end else if (i_sts.n_over_lim) begin
                    n_state = S_DEL_START;
                end else begin
                    n_state = S_MED_RD0;
                end
            end
            S_DEL_START: begin
                w_cmd.idx_zero = 1'b1;
                n_found        = 1'b0;
                n_state        = S_DEL_RD;
            end
            S_DEL_RD: begin
                w_cmd.rd_en = 1'b1;
                n_state     = S_DEL_ACT;
            end
            S_DEL_ACT: begin
                if (r_found) begin
                    w_cmd.wr_en  = 1'b1;
                    w_cmd.wr_sel = WR_DEL;
                end
                if (i_sts.age_match) begin
                    n_found = 1'b1;
                end
                if (i_sts.idx_last) begin
                    w_cmd.cnt_dec = 1'b1;
                    n_state       = S_NEXT;
                end else begin
                    w_cmd.idx_inc = 1'b1;
                    n_state       = S_DEL_RD;
                end
            end
            S_INS_START: begin
                n_pend = 1'b0;
                if (i_sts.n_zero) begin
                    w_cmd.wr_en   = 1'b1;
                    w_cmd.wr_sel  = WR_NEW_ZERO;
                    w_cmd.cnt_inc = 1'b1;
                    n_state       = S_NEXT;
                end else begin
                    w_cmd.idx_top = 1'b1;
                    n_state       = S_INS_RD;
                end
            end
            S_INS_RD: begin
                w_cmd.rd_en = 1'b1;
                n_state     = S_INS_ACT;
            end
            S_INS_ACT: begin
                w_cmd.wr_en = 1'b1;
                if (i_sts.greater) begin
                    w_cmd.wr_sel = WR_SHIFT;
                    if (i_sts.idx_zero) begin
                        n_state = S_INS_LAST;
                    end else begin
                        w_cmd.idx_dec = 1'b1;
                        n_state       = S_INS_RD;
                    end
                end else begin
                    w_cmd.wr_sel  = WR_NEW_UP;
                    w_cmd.cnt_inc = 1'b1;
                    n_state       = S_NEXT;
                end
            end
            S_INS_LAST: begin
                w_cmd.wr_en   = 1'b1;
                w_cmd.wr_sel  = WR_NEW_ZERO;
                w_cmd.cnt_inc = 1'b1;
                n_state       = S_NEXT;
            end
            S_MED_RD0: begin
                if (i_sts.n_zero) begin
                    w_cmd.med_zero = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = RD_MID;
                    n_state      = S_MED_RD1;
                end
            end
            S_MED_RD1: begin
                if (i_sts.n_odd) begin
                    w_cmd.med_odd = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    w_cmd.med_hi = 1'b1;
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = RD_MID_M1;
                    n_state      = S_MED_LO;
                end
            end
            S_MED_LO: begin
                w_cmd.med_sum = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_found     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_found     <= n_found;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd   = w_cmd;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

>>> rtl/swm_datapath.sv
// ----------------------------------------------------------------------------
// Sliding window median datapath
// Holds the window as a sorted memory tagged with arrival ages, the fill
// count, the scan index, the limit register and the output register.
// ----------------------------------------------------------------------------
module swm_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [swm_pkg::LIMIT_BITS-1:0]        i_cfg_data,
    input  logic signed [swm_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                  i_sample_valid,
    input  swm_pkg::t_cmd                         i_cmd,
    output swm_pkg::t_sts                         o_sts,
    output logic signed [swm_pkg::OUT_BITS-1:0]   o_median_doubled,
    output logic [swm_pkg::COUNT_BITS-1:0]        o_window_count,
    output logic                                  o_median_valid
);
    import swm_pkg::*;

    t_entry                  r_mem [WINDOW_DEPTH];
    t_entry                  r_rdata;
    logic [LIMIT_BITS-1:0]   r_limit;
    logic [COUNT_BITS-1:0]   r_count;
    logic [ADDR_BITS-1:0]    r_seq;
    logic [ADDR_BITS-1:0]    r_idx;
    logic [SAMPLE_BITS-1:0]  r_sample;
    logic                    r_samp_valid;
    logic [SAMPLE_BITS-1:0]  r_hi;
    logic [OUT_BITS-1:0]     r_acc;
    logic [OUT_BITS-1:0]     r_out_med;
    logic [COUNT_BITS-1:0]   r_out_count;
    logic                    r_out_mvalid;

    logic [COUNT_BITS-1:0]   w_count_m1;
    logic [COUNT_BITS-1:0]   w_half;
    logic [ADDR_BITS-1:0]    w_target;
    logic [ADDR_BITS-1:0]    w_rd_addr;
    logic [ADDR_BITS-1:0]    w_wr_addr;
    t_entry                  w_wr_data;
    t_entry                  w_new;

    assign w_count_m1 = r_count - COUNT_BITS'(1);
    assign w_half     = r_count >> 1;
    assign w_target   = r_seq - r_count[ADDR_BITS-1:0];
    assign w_new      = '{value: r_sample, age: r_seq};

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_MID:    w_rd_addr = w_half[ADDR_BITS-1:0];
            RD_MID_M1: w_rd_addr = w_half[ADDR_BITS-1:0] - ADDR_BITS'(1);
            default:   w_rd_addr = r_idx;
        endcase
    end

    always_comb begin
        unique case (i_cmd.wr_sel)
            WR_DEL: begin
                w_wr_addr = r_idx - ADDR_BITS'(1);
                w_wr_data = r_rdata;
            end
            WR_SHIFT: begin
                w_wr_addr = r_idx + ADDR_BITS'(1);
                w_wr_data = r_rdata;
            end
            WR_NEW_UP: begin
                w_wr_addr = r_idx + ADDR_BITS'(1);
                w_wr_data = w_new;
            end
            default: begin
                w_wr_addr = '0;
                w_wr_data = w_new;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_count <= '0;
            r_seq   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + COUNT_BITS'(1);
                r_seq   <= r_seq + ADDR_BITS'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= w_count_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_sample     <= i_sample;
            r_samp_valid <= i_sample_valid;
        end
        if (i_cmd.idx_zero) begin
            r_idx <= '0;
        end else if (i_cmd.idx_top) begin
            r_idx <= w_count_m1[ADDR_BITS-1:0];
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + ADDR_BITS'(1);
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - ADDR_BITS'(1);
        end
        if (i_cmd.med_zero) begin
            r_acc <= '0;
        end else if (i_cmd.med_odd) begin
            r_acc <= {r_rdata.value, 1'b0};
        end else if (i_cmd.med_sum) begin
            r_acc <= {r_hi[SAMPLE_BITS-1], r_hi}
                   + {r_rdata.value[SAMPLE_BITS-1], r_rdata.value};
        end
        if (i_cmd.med_hi) begin
            r_hi <= r_rdata.value;
        end
        if (i_cmd.out_load) begin
            r_out_med    <= r_acc;
            r_out_count  <= r_count;
            r_out_mvalid <= (r_count != '0);
        end
    end

    always_comb begin
        o_sts.samp_valid = r_samp_valid;
        o_sts.n_zero     = (r_count == '0);
        o_sts.n_full     = (r_count == COUNT_BITS'(WINDOW_DEPTH));
        o_sts.n_over_lim = (CMP_BITS'(r_count) > CMP_BITS'(r_limit));
        o_sts.n_odd      = r_count[0];
        o_sts.idx_last   = (COUNT_BITS'(r_idx) == w_count_m1);
        o_sts.idx_zero   = (r_idx == '0);
        o_sts.age_match  = (r_rdata.age == w_target);
        o_sts.greater    = ($signed(r_rdata.value) > $signed(r_sample));
    end

    assign o_median_doubled = $signed(r_out_med);
    assign o_window_count   = r_out_count;
    assign o_median_valid   = r_out_mvalid;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_BITS'(WINDOW_DEPTH))
        else $error("window count above depth");

    a_inc_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |-> r_count != COUNT_BITS'(WINDOW_DEPTH))
        else $error("insertion into a full window");

    a_dec_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_dec |-> r_count != '0)
        else $error("removal from an empty window");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_en && (i_cmd.wr_sel == WR_SHIFT || i_cmd.wr_sel == WR_NEW_UP))
        |-> r_idx != {ADDR_BITS{1'b1}})
        else $error("upward shift past the last entry");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> o_window_count == $past(r_count))
        else $error("output count does not match window");

endmodule

>>> rtl/sliding_window_median_core.sv
// ----------------------------------------------------------------------------
// Sliding window median core
// Keeps a bounded window of the most recent valid samples in sorted order and
// returns twice the median after each input word.
//
//   channel   signals                                  direction
//   input     i_valid / o_ready, i_sample, i_sample_valid   in
//   output    o_valid / i_ready, o_median_doubled,
//             o_window_count, o_median_valid                out
//   config    i_cfg_we, i_cfg_data (window limit)           in
//
// A word with nothing to insert or drop goes from acceptance through the
// middle-entry read to the output load; an empty window skips the read and
// an even count adds a read of the lower middle entry. An insertion reads
// entries going down from the top and adds a write when the sample lands at
// the bottom. Each removal of the oldest entry reads the whole window. The
// reset is synchronous and the memory is not swept. A stalled result waits in
// the output register; the next word is still accepted and waits to load.
// ----------------------------------------------------------------------------
module sliding_window_median_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [swm_pkg::LIMIT_BITS-1:0]         i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [swm_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                   i_sample_valid,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [swm_pkg::OUT_BITS-1:0]    o_median_doubled,
    output logic [swm_pkg::COUNT_BITS-1:0]         o_window_count,
    output logic                                   o_median_valid
);
    import swm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    swm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    swm_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_sample         (i_sample),
        .i_sample_valid   (i_sample_valid),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_median_doubled (o_median_doubled),
        .o_window_count   (o_window_count),
        .o_median_valid   (o_median_valid)
    );

endmodule
